[hw/rtl/i2cm_pkg.sv]
package i2cm_pkg;

    localparam int TIMER_BITS_DEF = 16;

    localparam int HP_W    = 16;
    localparam int ATO_W   = 8;
    localparam int BYTE_W  = 8;
    localparam int MODE_W  = 3;
    localparam int BIT_W   = 4;

    localparam logic [HP_W-1:0]  HALF_PERIOD_RST = 16'd5;
    localparam logic [ATO_W-1:0] ACK_TIMEOUT_RST = 8'd250;
    localparam logic [BIT_W-1:0] BITS_PER_BYTE   = 4'd8;

    localparam logic REG_HALF_PERIOD = 1'b0;
    localparam logic REG_ACK_TIMEOUT = 1'b1;

    localparam logic [MODE_W-1:0] MODE_NONE  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_START = 3'd1;
    localparam logic [MODE_W-1:0] MODE_STOP  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_WRITE = 3'd3;
    localparam logic [MODE_W-1:0] MODE_RDACK = 3'd4;
    localparam logic [MODE_W-1:0] MODE_RDNAK = 3'd5;
    localparam logic [MODE_W-1:0] MODE_CHECK = 3'd6;

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_ST_A,
        PH_ST_B,
        PH_SP_A,
        PH_SP_B,
        PH_SP_C,
        PH_WR_LO,
        PH_WR_HI,
        PH_WR_TAIL,
        PH_RD_LO,
        PH_RD_HI,
        PH_AK_LO,
        PH_AK_HI,
        PH_CK_LO,
        PH_CK_HI,
        PH_CK_POLL
    } t_phase;

    typedef struct packed {
        logic              scl_level;
        logic              sda_level;
        logic              sda_drive;
        logic              busy_res;
        logic              done_res;
        logic [BYTE_W-1:0] read_byte;
        logic              ack_ok;
        logic              rejected;
    } t_result;

endpackage

[hw/rtl/i2c_bit_level_master_core.sv]
// channel     | direction | handshake               | payload
// ------------+-----------+-------------------------+-----------------------------------------
// input item  | in        | i_in_valid / o_in_stall | i_mode, i_write_byte, i_sda_in
// result item | out       | o_out_valid/ i_out_stall| o_scl_level .. o_rejected
// config      | in        | i_cfg_valid/ o_cfg_ready| i_cfg_index, i_cfg_data
//
// one transaction per cycle unless o_in_stall is high: each input item is one bus tick,
// its result is registered (in the skid register if the output stalls)
// the sequencer state and the result are updated in one pass from the registered state
// a two-entry output stage (result register plus skid register) keeps o_in_stall registered;
// input is stalled only while both entries are full
// i_rst_n is synchronous, active low, and puts the bus idle high with SDA driven

module i2c_bit_level_master_core #(
    parameter int TIMER_BITS = i2cm_pkg::TIMER_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [2:0]  i_mode,
    input  logic [7:0]  i_write_byte,
    input  logic        i_sda_in,

    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_scl_level,
    output logic        o_sda_level,
    output logic        o_sda_drive,
    output logic        o_busy_res,
    output logic        o_done_res,
    output logic [7:0]  o_read_byte,
    output logic        o_ack_ok,
    output logic        o_rejected,

    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    import i2cm_pkg::*;

    logic [HP_W-1:0]       r_half_period;
    logic [ATO_W-1:0]      r_ack_timeout;

    t_phase                r_phase, n_phase;
    logic [MODE_W-1:0]     r_cmd, n_cmd;
    logic [BIT_W-1:0]      r_bit, n_bit;
    logic [TIMER_BITS-1:0] r_timer, n_timer;
    logic [BYTE_W-1:0]     r_shift, n_shift;
    logic [ATO_W-1:0]      r_poll, n_poll;
    logic                  r_scl, n_scl;
    logic                  r_sda, n_sda;
    logic                  r_drv, n_drv;
    logic [BYTE_W-1:0]     r_read, n_read;
    logic                  r_ack, n_ack;
    logic                  n_done;
    logic                  n_rej;

    t_result               r_out, r_skid, w_res;
    logic                  r_out_valid, r_skid_valid;

    logic [HP_W-1:0]       w_hp_m1;
    logic [TIMER_BITS-1:0] w_reload;
    logic                  w_in_acc;
    logic                  w_out_take;
    logic [BIT_W-1:0]      w_bit_inc;
    logic [BYTE_W-1:0]     w_shift_wr;
    logic [BYTE_W-1:0]     w_shift_rd;

    assign w_hp_m1 = (r_half_period == '0) ? '0 : r_half_period - HP_W'(1);

    generate
        if (TIMER_BITS >= HP_W) begin : g_wide_timer
            assign w_reload = TIMER_BITS'(w_hp_m1);
        end else begin : g_narrow_timer
            assign w_reload = ((w_hp_m1 >> TIMER_BITS) != '0) ? '1 : w_hp_m1[TIMER_BITS-1:0];
        end
    endgenerate

    assign w_bit_inc  = r_bit + BIT_W'(1);
    assign w_shift_wr = {r_shift[BYTE_W-2:0], 1'b0};
    assign w_shift_rd = {r_shift[BYTE_W-2:0], i_sda_in};

    always_comb begin
        n_phase = r_phase;
        n_cmd   = r_cmd;
        n_bit   = r_bit;
        n_timer = r_timer;
        n_shift = r_shift;
        n_poll  = r_poll;
        n_scl   = r_scl;
        n_sda   = r_sda;
        n_drv   = r_drv;
        n_read  = r_read;
        n_ack   = r_ack;
        n_done  = 1'b0;
        n_rej   = 1'b0;

        if (r_phase == PH_IDLE) begin
            if (i_mode inside {[MODE_START:MODE_CHECK]}) begin
                n_cmd   = i_mode;
                n_bit   = '0;
                n_timer = w_reload;
                case (i_mode)
                    MODE_START: begin
                        n_phase = PH_ST_A;
                        n_scl = 1'b1; n_sda = 1'b1; n_drv = 1'b1;
                    end
                    MODE_STOP: begin
                        n_phase = PH_SP_A;
                        n_scl = 1'b0; n_sda = 1'b0; n_drv = 1'b1;
                    end
                    MODE_WRITE: begin
                        n_shift = i_write_byte;
                        n_phase = PH_WR_LO;
                        n_scl = 1'b0; n_sda = i_write_byte[BYTE_W-1]; n_drv = 1'b1;
                    end
                    MODE_RDACK, MODE_RDNAK: begin
                        n_shift = '0;
                        n_phase = PH_RD_LO;
                        n_scl = 1'b0; n_sda = 1'b1; n_drv = 1'b0;
                    end
                    default: begin
                        n_poll  = '0;
                        n_phase = PH_CK_LO;
                        n_scl = 1'b0; n_sda = 1'b1; n_drv = 1'b0;
                    end
                endcase
            end
        end else begin
            n_rej = i_mode inside {[MODE_START:MODE_CHECK]};
            if (r_phase == PH_CK_POLL) begin
                if (!i_sda_in) begin
                    n_scl   = 1'b0;
                    n_ack   = 1'b1;
                    n_phase = PH_IDLE;
                    n_timer = '0;
                    n_done  = 1'b1;
                end else if (r_poll >= r_ack_timeout) begin
                    n_phase = PH_SP_A;
                    n_timer = w_reload;
                    n_scl = 1'b0; n_sda = 1'b0; n_drv = 1'b1;
                end else begin
                    n_poll = r_poll + ATO_W'(1);
                end
            end else if (r_timer != '0) begin
                n_timer = r_timer - TIMER_BITS'(1);
            end else begin
                n_timer = w_reload;
                case (r_phase)
                    PH_ST_A: begin
                        n_phase = PH_ST_B;
                        n_scl = 1'b1; n_sda = 1'b0; n_drv = 1'b1;
                    end
                    PH_SP_A: begin
                        n_phase = PH_SP_B;
                        n_scl = 1'b1; n_sda = 1'b0; n_drv = 1'b1;
                    end
                    PH_SP_B: begin
                        n_phase = PH_SP_C;
                        n_scl = 1'b1; n_sda = 1'b1; n_drv = 1'b1;
                    end
                    PH_WR_LO: begin
                        n_phase = PH_WR_HI;
                        n_scl = 1'b1; n_drv = 1'b1;
                    end
                    PH_WR_HI: begin
                        n_phase = PH_WR_TAIL;
                        n_scl = 1'b0; n_drv = 1'b1;
                    end
                    PH_WR_TAIL: begin
                        n_shift = w_shift_wr;
                        n_bit   = w_bit_inc;
                        if (w_bit_inc >= BITS_PER_BYTE) begin
                            n_phase = PH_IDLE;
                            n_timer = '0;
                            n_done  = 1'b1;
                        end else begin
                            n_phase = PH_WR_LO;
                            n_scl = 1'b0; n_sda = w_shift_wr[BYTE_W-1]; n_drv = 1'b1;
                        end
                    end
                    PH_RD_LO: begin
                        n_phase = PH_RD_HI;
                        n_shift = w_shift_rd;
                        n_scl = 1'b1; n_sda = 1'b1; n_drv = 1'b0;
                    end
                    PH_RD_HI: begin
                        n_bit = w_bit_inc;
                        if (w_bit_inc >= BITS_PER_BYTE) begin
                            n_read  = r_shift;
                            n_phase = PH_AK_LO;
                            n_scl = 1'b0; n_sda = (r_cmd == MODE_RDNAK); n_drv = 1'b1;
                        end else begin
                            n_phase = PH_RD_LO;
                            n_scl = 1'b0; n_sda = 1'b1; n_drv = 1'b0;
                        end
                    end
                    PH_AK_LO: begin
                        n_phase = PH_AK_HI;
                        n_scl = 1'b1; n_drv = 1'b1;
                    end
                    PH_CK_LO: begin
                        n_phase = PH_CK_HI;
                        n_scl = 1'b1; n_sda = 1'b1; n_drv = 1'b0;
                    end
                    PH_CK_HI: begin
                        n_phase = PH_CK_POLL;
                        n_timer = r_timer;
                    end
                    PH_ST_B, PH_AK_HI: begin
                        n_scl   = 1'b0;
                        n_phase = PH_IDLE;
                        n_timer = '0;
                        n_done  = 1'b1;
                    end
                    PH_SP_C: begin
                        if (r_cmd == MODE_CHECK) begin
                            n_ack = 1'b0;
                        end
                        n_phase = PH_IDLE;
                        n_timer = '0;
                        n_done  = 1'b1;
                    end
                    default: begin
                        n_phase = PH_IDLE;
                        n_timer = '0;
                        n_done  = 1'b1;
                    end
                endcase
            end
        end

        w_res.scl_level = n_scl;
        w_res.sda_level = n_sda;
        w_res.sda_drive = n_drv;
        w_res.busy_res  = (n_phase != PH_IDLE);
        w_res.done_res  = n_done;
        w_res.read_byte = n_read;
        w_res.ack_ok    = n_ack;
        w_res.rejected  = n_rej;
    end

    assign o_in_stall  = r_skid_valid;
    assign w_in_acc    = i_in_valid && !r_skid_valid;
    assign w_out_take  = r_out_valid && !i_out_stall;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_period <= HALF_PERIOD_RST;
            r_ack_timeout <= ACK_TIMEOUT_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_HALF_PERIOD: r_half_period <= i_cfg_data;
                REG_ACK_TIMEOUT: r_ack_timeout <= i_cfg_data[ATO_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_cmd   <= '0;
            r_bit   <= '0;
            r_timer <= '0;
            r_shift <= '0;
            r_poll  <= '0;
            r_scl   <= 1'b1;
            r_sda   <= 1'b1;
            r_drv   <= 1'b1;
            r_read  <= '0;
            r_ack   <= 1'b0;
        end else if (w_in_acc) begin
            r_phase <= n_phase;
            r_cmd   <= n_cmd;
            r_bit   <= n_bit;
            r_timer <= n_timer;
            r_shift <= n_shift;
            r_poll  <= n_poll;
            r_scl   <= n_scl;
            r_sda   <= n_sda;
            r_drv   <= n_drv;
            r_read  <= n_read;
            r_ack   <= n_ack;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || w_out_take) begin
            r_out_valid  <= r_skid_valid || w_in_acc;
            r_skid_valid <= 1'b0;
        end else if (w_in_acc) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || w_out_take) begin
            r_out <= r_skid_valid ? r_skid : w_res;
        end
        if (r_out_valid && !w_out_take && w_in_acc) begin
            r_skid <= w_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_scl_level = r_out.scl_level;
    assign o_sda_level = r_out.sda_level;
    assign o_sda_drive = r_out.sda_drive;
    assign o_busy_res  = r_out.busy_res;
    assign o_done_res  = r_out.done_res;
    assign o_read_byte = r_out.read_byte;
    assign o_ack_ok    = r_out.ack_ok;
    assign o_rejected  = r_out.rejected;

    a_idle_timer_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_IDLE) |-> (r_timer == '0))
        else $error("phase timer not cleared in idle");

    a_bit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bit <= BITS_PER_BYTE)
        else $error("bit index out of range");

    a_sda_released: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_RD_LO || r_phase == PH_RD_HI || r_phase == PH_CK_LO ||
         r_phase == PH_CK_HI || r_phase == PH_CK_POLL) |-> (!r_drv && r_sda))
        else $error("sda driven while sampling");

    a_skid_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry held without output entry");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && n_done) |=> (r_phase == PH_IDLE))
        else $error("command finished but sequencer not idle");

endmodule

[verif/i2c_bit_level_master_core_tb.sv]
module i2c_bit_level_master_core_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import i2cm_pkg::*;

    localparam logic [MODE_W-1:0] MODE_UNUSED = 3'd7;
    localparam int SDA_LOW  = 0;
    localparam int SDA_HIGH = 1;
    localparam int SDA_RAND = 2;
    localparam int CYCLE_LIMIT = 3_000_000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [2:0]  i_mode;
    logic [7:0]  i_write_byte;
    logic        i_sda_in;
    logic        o_out_valid;
    logic        i_out_stall;
    logic        o_scl_level;
    logic        o_sda_level;
    logic        o_sda_drive;
    logic        o_busy_res;
    logic        o_done_res;
    logic [7:0]  o_read_byte;
    logic        o_ack_ok;
    logic        o_rejected;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic        i_cfg_index;
    logic [15:0] i_cfg_data;

    i2c_bit_level_master_core dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_mode       (i_mode),
        .i_write_byte (i_write_byte),
        .i_sda_in     (i_sda_in),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_scl_level  (o_scl_level),
        .o_sda_level  (o_sda_level),
        .o_sda_drive  (o_sda_drive),
        .o_busy_res   (o_busy_res),
        .o_done_res   (o_done_res),
        .o_read_byte  (o_read_byte),
        .o_ack_ok     (o_ack_ok),
        .o_rejected   (o_rejected),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    // bus sequencer mirror
    t_phase             m_phase;
    logic [MODE_W-1:0]  m_cmd;
    logic [BIT_W-1:0]   m_bit;
    logic [HP_W-1:0]    m_timer;
    logic [BYTE_W-1:0]  m_shift;
    logic [ATO_W-1:0]   m_polls;
    logic               m_scl;
    logic               m_sda;
    logic               m_drv;
    logic [BYTE_W-1:0]  m_rd;
    logic               m_ack;
    logic               m_done;
    logic [HP_W-1:0]    cfg_half;
    logic [ATO_W-1:0]   cfg_ato;

    t_result pending_levels[$];

    int src_idle_pct;
    int rx_stall_pct;
    int mismatches;
    int results_checked;
    int ticks_sent;
    int commands_by_mode[8];
    int turned_away;
    int ack_timeouts;
    int cycle_count;

    function automatic void enter_phase(input t_phase ph, input logic scl, input logic sda,
                                        input logic drv);
        m_timer = (cfg_half == '0) ? '0 : cfg_half - 16'd1;
        m_phase = ph;
        m_scl   = scl;
        m_sda   = drv ? sda : 1'b1;
        m_drv   = drv;
    endfunction

    function automatic void finish_seq();
        m_phase = PH_IDLE;
        m_timer = '0;
        m_done  = 1'b1;
    endfunction

    function automatic void advance_phase(input logic sda_in);
        case (m_phase)
            PH_ST_A: enter_phase(PH_ST_B, 1'b1, 1'b0, 1'b1);
            PH_ST_B: begin
                m_scl = 1'b0;
                finish_seq();
            end
            PH_SP_A: enter_phase(PH_SP_B, 1'b1, 1'b0, 1'b1);
            PH_SP_B: enter_phase(PH_SP_C, 1'b1, 1'b1, 1'b1);
            PH_SP_C: begin
                if (m_cmd == MODE_CHECK) m_ack = 1'b0;
                finish_seq();
            end
            PH_WR_LO: enter_phase(PH_WR_HI, 1'b1, m_sda, 1'b1);
            PH_WR_HI: enter_phase(PH_WR_TAIL, 1'b0, m_sda, 1'b1);
            PH_WR_TAIL: begin
                m_shift = m_shift << 1;
                m_bit   = m_bit + 1'b1;
                if (m_bit >= BITS_PER_BYTE) finish_seq();
                else enter_phase(PH_WR_LO, 1'b0, m_shift[7], 1'b1);
            end
            PH_RD_LO: begin
                enter_phase(PH_RD_HI, 1'b1, 1'b1, 1'b0);
                m_shift = {m_shift[6:0], sda_in};
            end
            PH_RD_HI: begin
                m_bit = m_bit + 1'b1;
                if (m_bit >= BITS_PER_BYTE) begin
                    m_rd = m_shift;
                    enter_phase(PH_AK_LO, 1'b0, m_cmd == MODE_RDNAK, 1'b1);
                end else begin
                    enter_phase(PH_RD_LO, 1'b0, 1'b1, 1'b0);
                end
            end
            PH_AK_LO: enter_phase(PH_AK_HI, 1'b1, m_sda, 1'b1);
            PH_AK_HI: begin
                m_scl = 1'b0;
                finish_seq();
            end
            PH_CK_LO: enter_phase(PH_CK_HI, 1'b1, 1'b1, 1'b0);
            PH_CK_HI: m_phase = PH_CK_POLL;
            default: finish_seq();
        endcase
    endfunction

    // one bus tick: returns the pin levels and status seen after it
    function automatic t_result bus_tick(input logic [MODE_W-1:0] mode,
                                         input logic [BYTE_W-1:0] wbyte, input logic sda_in);
        t_result r;
        logic    is_cmd;
        is_cmd = (mode >= MODE_START) && (mode <= MODE_CHECK);
        r.rejected = 1'b0;
        m_done = 1'b0;
        if (m_phase == PH_IDLE) begin
            if (is_cmd) begin
                commands_by_mode[mode]++;
                m_cmd = mode;
                m_bit = '0;
                case (mode)
                    MODE_START: enter_phase(PH_ST_A, 1'b1, 1'b1, 1'b1);
                    MODE_STOP:  enter_phase(PH_SP_A, 1'b0, 1'b0, 1'b1);
                    MODE_WRITE: begin
                        m_shift = wbyte;
                        enter_phase(PH_WR_LO, 1'b0, wbyte[7], 1'b1);
                    end
                    MODE_RDACK, MODE_RDNAK: begin
                        m_shift = '0;
                        enter_phase(PH_RD_LO, 1'b0, 1'b1, 1'b0);
                    end
                    default: begin
                        m_polls = '0;
                        enter_phase(PH_CK_LO, 1'b0, 1'b1, 1'b0);
                    end
                endcase
            end
        end else begin
            if (is_cmd) begin
                r.rejected = 1'b1;
                turned_away++;
            end
            if (m_phase == PH_CK_POLL) begin
                if (!sda_in) begin
                    m_scl = 1'b0;
                    m_ack = 1'b1;
                    finish_seq();
                end else if (m_polls >= cfg_ato) begin
                    ack_timeouts++;
                    enter_phase(PH_SP_A, 1'b0, 1'b0, 1'b1);
                end else begin
                    m_polls = m_polls + 1'b1;
                end
            end else if (m_timer != '0) begin
                m_timer = m_timer - 1'b1;
            end else begin
                advance_phase(sda_in);
            end
        end
        r.scl_level = m_scl;
        r.sda_level = m_sda;
        r.sda_drive = m_drv;
        r.busy_res  = (m_phase != PH_IDLE);
        r.done_res  = m_done;
        r.read_byte = m_rd;
        r.ack_ok    = m_ack;
        return r;
    endfunction

    function automatic void bus_reset();
        cfg_half = HALF_PERIOD_RST;
        cfg_ato  = ACK_TIMEOUT_RST;
        m_phase  = PH_IDLE;
        m_cmd    = MODE_NONE;
        m_bit    = '0;
        m_timer  = '0;
        m_shift  = '0;
        m_polls  = '0;
        m_scl    = 1'b1;
        m_sda    = 1'b1;
        m_drv    = 1'b1;
        m_rd     = '0;
        m_ack    = 1'b0;
        m_done   = 1'b0;
    endfunction

    function automatic logic pick_sda(input int policy);
        if (policy == SDA_RAND) begin
            // mostly high while polling so that timeouts happen
            if (m_phase == PH_CK_POLL) return $urandom_range(0, 99) < 85;
            return 1'($urandom_range(0, 1));
        end
        return policy == SDA_HIGH;
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_levels.size());
            $display("[i2c_bit_level_master_core] ERROR");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        i_out_stall <= (rx_stall_pct != 0) && ($urandom_range(0, 99) < rx_stall_pct);
    end

    always @(posedge i_clk) begin : check_levels
        t_result got;
        t_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got = {o_scl_level, o_sda_level, o_sda_drive, o_busy_res, o_done_res,
                   o_read_byte, o_ack_ok, o_rejected};
            if (pending_levels.size() == 0) begin
                if (mismatches < 10)
                    $display("unexpected result transaction at cycle %0d", cycle_count);
                mismatches++;
            end else begin
                want = pending_levels.pop_front();
                results_checked++;
                if (got !== want) begin
                    if (mismatches < 10) begin
                        $display("mismatch at cycle %0d (result %0d)", cycle_count,
                                 results_checked);
                        $display("  exp scl %b sda %b drv %b busy %b done %b rd %h ack %b rej %b",
                                 want.scl_level, want.sda_level, want.sda_drive,
                                 want.busy_res, want.done_res, want.read_byte,
                                 want.ack_ok, want.rejected);
                        $display("  got scl %b sda %b drv %b busy %b done %b rd %h ack %b rej %b",
                                 got.scl_level, got.sda_level, got.sda_drive,
                                 got.busy_res, got.done_res, got.read_byte,
                                 got.ack_ok, got.rejected);
                    end
                    mismatches++;
                end
            end
        end
    end

    task automatic send_tick(input logic [MODE_W-1:0] mode, input logic [BYTE_W-1:0] wbyte,
                             input logic sda);
        while (src_idle_pct != 0 && $urandom_range(0, 99) < src_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_mode       <= mode;
        i_write_byte <= wbyte;
        i_sda_in     <= sda;
        do @(posedge i_clk); while (o_in_stall);
        ticks_sent++;
        pending_levels.push_back(bus_tick(mode, wbyte, sda));
    endtask

    task automatic finish_command(input int policy);
        while (m_phase != PH_IDLE)
            send_tick(MODE_NONE, BYTE_W'($urandom_range(0, 255)), pick_sda(policy));
    endtask

    task automatic run_command(input logic [MODE_W-1:0] mode, input logic [BYTE_W-1:0] wbyte,
                               input int policy);
        send_tick(mode, wbyte, pick_sda(policy));
        finish_command(policy);
    endtask

    // both registers, back to back, with the bus idle and all results in
    task automatic set_timing(input logic [HP_W-1:0] hp, input logic [ATO_W-1:0] ato);
        i_in_valid <= 1'b0;
        while (pending_levels.size() != 0) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= REG_HALF_PERIOD;
        i_cfg_data  <= hp;
        do @(posedge i_clk); while (!o_cfg_ready);
        cfg_half = hp;
        i_cfg_index <= REG_ACK_TIMEOUT;
        i_cfg_data  <= {8'h00, ato};
        do @(posedge i_clk); while (!o_cfg_ready);
        cfg_ato = ato;
        i_cfg_valid <= 1'b0;
    endtask

    task automatic test_start_stop();
        send_tick(MODE_UNUSED, 8'h00, 1'b1);
        run_command(MODE_START, 8'h00, SDA_RAND);
        run_command(MODE_STOP, 8'hFF, SDA_RAND);
        send_tick(MODE_NONE, 8'h00, 1'b0);
    endtask

    task automatic test_write_bytes();
        set_timing(16'd1, ACK_TIMEOUT_RST);
        run_command(MODE_WRITE, 8'h00, SDA_RAND);
        run_command(MODE_WRITE, 8'hFF, SDA_RAND);
        run_command(MODE_WRITE, 8'hA5, SDA_RAND);
    endtask

    task automatic test_reads();
        run_command(MODE_RDACK, 8'h00, SDA_HIGH);
        run_command(MODE_RDNAK, 8'h00, SDA_LOW);
        run_command(MODE_RDACK, 8'h00, SDA_RAND);
        run_command(MODE_RDNAK, 8'h00, SDA_RAND);
    endtask

    task automatic test_ack_check();
        set_timing(16'd1, 8'd3);
        run_command(MODE_CHECK, 8'h00, SDA_LOW);
        run_command(MODE_CHECK, 8'h00, SDA_HIGH);
        set_timing(16'd1, 8'd1);
        run_command(MODE_CHECK, 8'h00, SDA_HIGH);
        // a zero timeout gives up on the first high poll
        set_timing(16'd1, 8'd0);
        run_command(MODE_CHECK, 8'h00, SDA_HIGH);
        run_command(MODE_CHECK, 8'h00, SDA_LOW);
        set_timing(16'd1, 8'd255);
        run_command(MODE_CHECK, 8'h00, SDA_RAND);
    endtask

    task automatic test_busy_commands();
        int m;
        send_tick(MODE_WRITE, 8'h3C, 1'b0);
        for (m = MODE_START; m <= MODE_UNUSED; m++)
            send_tick(m[MODE_W-1:0], BYTE_W'($urandom_range(0, 255)),
                      1'($urandom_range(0, 1)));
        finish_command(SDA_RAND);
    endtask

    task automatic test_half_period_extremes();
        // a zero half period behaves as one tick
        set_timing(16'd0, ACK_TIMEOUT_RST);
        run_command(MODE_START, 8'h00, SDA_RAND);
        run_command(MODE_WRITE, 8'h96, SDA_RAND);
        run_command(MODE_RDNAK, 8'h00, SDA_RAND);
        set_timing(16'd30, ACK_TIMEOUT_RST);
        run_command(MODE_START, 8'h00, SDA_RAND);
        set_timing(16'd1, ACK_TIMEOUT_RST);
        run_command(MODE_STOP, 8'h00, SDA_RAND);
    endtask

    task automatic test_random(input int src_pct, input int rx_pct, input logic [HP_W-1:0] hp,
                               input logic [ATO_W-1:0] ato, input int n_ticks);
        logic [MODE_W-1:0] mode;
        int k;
        set_timing(hp, ato);
        src_idle_pct = src_pct;
        rx_stall_pct = rx_pct;
        for (k = 0; k < n_ticks; k++) begin
            if (m_phase == PH_IDLE) begin
                if ($urandom_range(0, 99) < 75)
                    mode = MODE_W'($urandom_range(MODE_START, MODE_CHECK));
                else mode = $urandom_range(0, 1) ? MODE_UNUSED : MODE_NONE;
            end else begin
                // occasional command while busy
                if ($urandom_range(0, 99) < 8)
                    mode = MODE_W'($urandom_range(MODE_START, MODE_UNUSED));
                else mode = MODE_NONE;
            end
            send_tick(mode, BYTE_W'($urandom_range(0, 255)), pick_sda(SDA_RAND));
        end
        finish_command(SDA_RAND);
        src_idle_pct = 0;
        rx_stall_pct = 0;
    endtask

    initial begin
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_mode       = MODE_NONE;
        i_write_byte = '0;
        i_sda_in     = 1'b1;
        i_cfg_valid  = 1'b0;
        i_cfg_index  = REG_HALF_PERIOD;
        i_cfg_data   = '0;
        src_idle_pct = 0;
        rx_stall_pct = 0;
        ticks_sent   = 0;
        turned_away  = 0;
        ack_timeouts = 0;
        foreach (commands_by_mode[i]) commands_by_mode[i] = 0;
        bus_reset();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_start_stop();
        test_write_bytes();
        test_reads();
        test_ack_check();
        test_busy_commands();
        test_half_period_extremes();
        test_random(0, 0, 16'd1, 8'd3, 60);
        test_random(62, 0, 16'd0, 8'd0, 60);
        test_random(0, 62, 16'd3, 8'd8, 60);
        test_random(15, 15, 16'd2, 8'd255, 60);

        i_in_valid <= 1'b0;
        while (pending_levels.size() != 0) @(posedge i_clk);
        repeat (5) @(posedge i_clk);

        $display("%0d bus ticks, %0d results checked; start %0d stop %0d write %0d",
                 ticks_sent, results_checked, commands_by_mode[MODE_START],
                 commands_by_mode[MODE_STOP], commands_by_mode[MODE_WRITE]);
        $display("read+ack %0d read+nack %0d ack check %0d (%0d timed out), %0d turned away",
                 commands_by_mode[MODE_RDACK], commands_by_mode[MODE_RDNAK],
                 commands_by_mode[MODE_CHECK], ack_timeouts, turned_away);
        if (mismatches == 0 && pending_levels.size() == 0) begin
            $display("[i2c_bit_level_master_core] OK");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("[i2c_bit_level_master_core] ERROR");
        end
        $finish;
    end

endmodule
